// ===== sv/rusi_pkg.sv =====
// ---------------------------------------------------------------------------
// rusi_pkg
// Shared types and constants for the unit sphere ray intersection core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rusi_pkg;

   // root extraction: one result bit per step, two radicand bits per step
   localparam int RootSteps = 36;
   localparam int RemWidth  = RootSteps + 2;
   localparam int RadWidth  = 2 * RootSteps;

   // b = dot(dir, org) in Q19.16
   localparam int BWidth = 35;

   // hit classes
   localparam logic [2:0] CLASS_ENTER  = 3'd0;
   localparam logic [2:0] CLASS_EXIT   = 3'd1;
   localparam logic [2:0] CLASS_MISS   = 3'd2;
   localparam logic [2:0] CLASS_FAR    = 3'd3;
   localparam logic [2:0] CLASS_BEHIND = 3'd4;

   typedef struct packed {
      logic                     miss;
      logic signed [BWidth-1:0] b;
      logic signed [31:0]       max_distance;
   } side_type;

   typedef struct packed {
      logic [RadWidth-1:0]  rad;
      logic [RemWidth-1:0]  rem;
      logic [RootSteps-1:0] root;
   } root_type;

endpackage

`default_nettype wire

// ===== sv/rusi_front.sv =====
// ---------------------------------------------------------------------------
// rusi_front
// Six-stage front end: dot products, b and c, b squared, discriminant and
// miss test; seeds the root pipeline.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rusi_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire logic               in_valid,
   input  wire logic signed [31:0] origin_x,
   input  wire logic signed [31:0] origin_y,
   input  wire logic signed [31:0] origin_z,
   input  wire logic signed [17:0] dir_x,
   input  wire logic signed [17:0] dir_y,
   input  wire logic signed [17:0] dir_z,
   input  wire logic signed [31:0] max_distance,
   input  wire logic [15:0]        epsilon,
   output logic                    out_valid,
   output rusi_pkg::side_type      out_side,
   output rusi_pkg::root_type      out_root
);
   import rusi_pkg::*;

   logic [5:0] vld_ff;

   // stage 1
   logic signed [49:0] pbx_ff, pby_ff, pbz_ff;
   logic signed [49:0] pbx_in, pby_in, pbz_in;
   logic signed [63:0] sqx_ff, sqy_ff, sqz_ff;
   logic signed [63:0] sqx_in, sqy_in, sqz_in;
   logic signed [31:0] mx1_ff;

   // stage 2
   logic signed [50:0] bsum_ff, bsum_in;
   logic [63:0]        csum_ff, csum_in;
   logic signed [31:0] mx2_ff;

   // stage 3
   logic signed [BWidth-1:0] b3_in;
   logic [BWidth-1:0]        ub_ff, ub_in;
   logic signed [48:0]       c3_ff, c3_in;
   side_type                 s3_ff;

   // stage 4
   logic [18:0]        hi;
   logic [15:0]        lo;
   logic [37:0]        hh_ff, hh_in;
   logic [34:0]        hl_ff, hl_in;
   logic [31:0]        ll_ff, ll_in;
   logic signed [48:0] c4_ff;
   side_type           s4_ff;

   // stage 5
   logic [54:0]        bb_ff, bb_in;
   logic signed [48:0] c5_ff;
   side_type           s5_ff;

   // stage 6
   logic signed [55:0] d_in;
   side_type           s6_ff, s6_in;
   root_type           r6_ff, r6_in;

   always_comb begin
      pbx_in = 50'(dir_x) * 50'(origin_x);
      pby_in = 50'(dir_y) * 50'(origin_y);
      pbz_in = 50'(dir_z) * 50'(origin_z);
      sqx_in = 64'(origin_x) * 64'(origin_x);
      sqy_in = 64'(origin_y) * 64'(origin_y);
      sqz_in = 64'(origin_z) * 64'(origin_z);

      bsum_in = 51'(pbx_ff) + 51'(pby_ff) + 51'(pbz_ff);
      csum_in = 64'(sqx_ff) + 64'(sqy_ff) + 64'(sqz_ff);

      b3_in = bsum_ff[50:16];
      ub_in = b3_in[BWidth-1] ? BWidth'(-b3_in) : BWidth'(b3_in);
      c3_in = $signed({1'b0, csum_ff[63:16]}) - 49'sd65536;

      hi    = ub_ff[34:16];
      lo    = ub_ff[15:0];
      hh_in = 38'(hi) * 38'(hi);
      hl_in = 35'(hi) * 35'(lo);
      ll_in = 32'(lo) * 32'(lo);

      bb_in = {1'b0, hh_ff, 16'd0} + 55'({hl_ff, 1'b0}) + 55'(ll_ff[31:16]);

      d_in          = $signed({1'b0, bb_ff}) - 56'(c5_ff);
      s6_in         = s5_ff;
      s6_in.miss    = d_in < $signed(56'(epsilon));
      r6_in.rad     = {2'b00, d_in[53:0], 16'd0};
      r6_in.rem     = '0;
      r6_in.root    = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[4:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pbx_ff  <= pbx_in;
         pby_ff  <= pby_in;
         pbz_ff  <= pbz_in;
         sqx_ff  <= sqx_in;
         sqy_ff  <= sqy_in;
         sqz_ff  <= sqz_in;
         mx1_ff  <= max_distance;

         bsum_ff <= bsum_in;
         csum_ff <= csum_in;
         mx2_ff  <= mx1_ff;

         ub_ff              <= ub_in;
         c3_ff              <= c3_in;
         s3_ff.miss         <= 1'b0;
         s3_ff.b            <= b3_in;
         s3_ff.max_distance <= mx2_ff;

         hh_ff <= hh_in;
         hl_ff <= hl_in;
         ll_ff <= ll_in;
         c4_ff <= c3_ff;
         s4_ff <= s3_ff;

         bb_ff <= bb_in;
         c5_ff <= c4_ff;
         s5_ff <= s4_ff;

         s6_ff <= s6_in;
         r6_ff <= r6_in;
      end
   end

   assign out_valid = vld_ff[5];
   assign out_side  = s6_ff;
   assign out_root  = r6_ff;

endmodule

`default_nettype wire

// ===== sv/rusi_root_step.sv =====
// ---------------------------------------------------------------------------
// rusi_root_step
// One registered step of the bit-by-bit square root: takes two radicand
// bits, decides one root bit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rusi_root_step (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire logic               in_valid,
   input  wire rusi_pkg::side_type in_side,
   input  wire rusi_pkg::root_type in_root,
   output logic                    out_valid,
   output rusi_pkg::side_type      out_side,
   output rusi_pkg::root_type      out_root
);
   import rusi_pkg::*;

   logic                valid_ff;
   side_type            side_ff;
   root_type            root_ff, root_in;
   logic [RemWidth-1:0] rem_sh;
   logic [RemWidth-1:0] trial;

   always_comb begin
      rem_sh      = {in_root.rem[RemWidth-3:0], in_root.rad[RadWidth-1 -: 2]};
      trial       = {in_root.root, 2'b01};
      root_in.rad = {in_root.rad[RadWidth-3:0], 2'b00};
      if (rem_sh >= trial) begin
         root_in.rem  = rem_sh - trial;
         root_in.root = {in_root.root[RootSteps-2:0], 1'b1};
      end else begin
         root_in.rem  = rem_sh;
         root_in.root = {in_root.root[RootSteps-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff <= in_side;
         root_ff <= root_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_root  = root_ff;

endmodule

`default_nettype wire

// ===== sv/rusi_classify.sv =====
// ---------------------------------------------------------------------------
// rusi_classify
// Two stages: candidate distances, then class, hit flag and new distance.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rusi_classify (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  wire logic                          in_valid,
   input  wire rusi_pkg::side_type            in_side,
   input  wire logic [rusi_pkg::RootSteps-1:0] in_root,
   input  wire logic [15:0]                   epsilon,
   output logic                               out_valid,
   output logic                               out_hit,
   output logic [2:0]                         out_hit_class,
   output logic signed [31:0]                 out_distance
);
   import rusi_pkg::*;

   logic [1:0]         vld_ff;
   logic signed [37:0] l1_ff, l1_in, l2_ff, l2_in;
   logic               miss_ff;
   logic signed [31:0] maxd_ff;

   logic               hit_ff, hit_in;
   logic [2:0]         cls_ff, cls_in;
   logic signed [31:0] dist_ff, dist_in;
   logic signed [37:0] maxd_x, eps_x, pick;

   function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
      if (v > 38'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end else if (v < -38'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   always_comb begin
      l1_in = -38'(in_side.b) - $signed({2'b00, in_root});
      l2_in = -38'(in_side.b) + $signed({2'b00, in_root});

      maxd_x  = 38'(maxd_ff);
      eps_x   = $signed(38'(epsilon));
      hit_in  = 1'b0;
      pick    = '0;
      dist_in = maxd_ff;
      if (miss_ff) begin
         cls_in = CLASS_MISS;
      end else if (maxd_x < l1_ff) begin
         cls_in = CLASS_FAR;
      end else if (eps_x < l1_ff) begin
         cls_in = CLASS_ENTER;
         hit_in = 1'b1;
         pick   = l1_ff;
      end else if (maxd_x < l2_ff) begin
         cls_in = CLASS_FAR;
      end else if (eps_x < l2_ff) begin
         cls_in = CLASS_EXIT;
         hit_in = 1'b1;
         pick   = l2_ff;
      end else begin
         cls_in = CLASS_BEHIND;
      end
      if (hit_in) begin
         dist_in = sat32(pick);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         l1_ff   <= l1_in;
         l2_ff   <= l2_in;
         miss_ff <= in_side.miss;
         maxd_ff <= in_side.max_distance;
         hit_ff  <= hit_in;
         cls_ff  <= cls_in;
         dist_ff <= dist_in;
      end
   end

   assign out_valid     = vld_ff[1];
   assign out_hit       = hit_ff;
   assign out_hit_class = cls_ff;
   assign out_distance  = dist_ff;

endmodule

`default_nettype wire

// ===== sv/ray_unit_sphere_intersect_core.sv =====
// ---------------------------------------------------------------------------
// ray_unit_sphere_intersect_core
// Ray against the unit sphere at the origin in signed Q16.16: discriminant,
// pipelined square root, enter/exit/miss/far/behind class and new distance.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  origin xyz, dir xyz, max_distance
//   rsp_      out        rsp_valid/rsp_stall  hit, hit_class, distance
//   csr_      in/out     APB, pready tied     epsilon at byte address 0
//
// One request enters per cycle while not stalled. Six front stages, 36
// root stages (one root bit each), two classify stages and the output register.
// Reset clears all valid bits and sets epsilon to 1.
// A stalled result freezes the pipeline only when the last stage holds a
// request; otherwise requests keep flowing and fill the bubbles.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ray_unit_sphere_intersect_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [31:0] req_origin_x,
   input  wire logic signed [31:0] req_origin_y,
   input  wire logic signed [31:0] req_origin_z,
   input  wire logic signed [17:0] req_dir_x,
   input  wire logic signed [17:0] req_dir_y,
   input  wire logic signed [17:0] req_dir_z,
   input  wire logic signed [31:0] req_max_distance,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_hit,
   output logic [2:0]              rsp_hit_class,
   output logic signed [31:0]      rsp_distance,
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [2:0]         csr_paddr,
   input  wire logic [31:0]        csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);
   import rusi_pkg::*;

   localparam logic REG_EPSILON = 1'b0;

   logic [15:0] eps_ff;
   logic        advance;

   logic     vld   [0:RootSteps];
   side_type sides [0:RootSteps];
   root_type roots [0:RootSteps];

   logic               cls_valid;
   logic               cls_hit;
   logic [2:0]         cls_class;
   logic signed [31:0] cls_dist;

   logic               rsp_valid_ff;
   logic               rsp_hit_ff;
   logic [2:0]         rsp_class_ff;
   logic signed [31:0] rsp_dist_ff;

   // hold everything only when a finished request would be lost
   assign advance   = !(rsp_valid_ff && rsp_stall && cls_valid);
   assign req_stall = !advance;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_EPSILON) ? {16'd0, eps_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= 16'd1;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == REG_EPSILON) begin
         eps_ff <= csr_pwdata[15:0];
      end
   end

   rusi_front u_front (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_valid     (req_valid),
      .origin_x     (req_origin_x),
      .origin_y     (req_origin_y),
      .origin_z     (req_origin_z),
      .dir_x        (req_dir_x),
      .dir_y        (req_dir_y),
      .dir_z        (req_dir_z),
      .max_distance (req_max_distance),
      .epsilon      (eps_ff),
      .out_valid    (vld[0]),
      .out_side     (sides[0]),
      .out_root     (roots[0])
   );

   for (genvar i = 0; i < RootSteps; i++) begin : g_root
      rusi_root_step u_step (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (vld[i]),
         .in_side   (sides[i]),
         .in_root   (roots[i]),
         .out_valid (vld[i+1]),
         .out_side  (sides[i+1]),
         .out_root  (roots[i+1])
      );
   end

   rusi_classify u_classify (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .in_valid      (vld[RootSteps]),
      .in_side       (sides[RootSteps]),
      .in_root       (roots[RootSteps].root),
      .epsilon       (eps_ff),
      .out_valid     (cls_valid),
      .out_hit       (cls_hit),
      .out_hit_class (cls_class),
      .out_distance  (cls_dist)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || !rsp_stall) begin
         rsp_valid_ff <= cls_valid;
      end
   end

   always_ff @(posedge clock) begin
      if ((!rsp_valid_ff || !rsp_stall) && cls_valid) begin
         rsp_hit_ff   <= cls_hit;
         rsp_class_ff <= cls_class;
         rsp_dist_ff  <= cls_dist;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_hit_class = rsp_class_ff;
   assign rsp_distance  = rsp_dist_ff;

endmodule

`default_nettype wire
